>>> src/lmi_pkg.sv
`default_nettype none
package lmi_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SpeedFrac = 16;
  localparam int unsigned FracBitsDef = 8;
  localparam logic [31:0] SpeedReset = 32'h0001_0000;

  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_RETGT  = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic CFG_WALK = 1'b0;
  localparam logic CFG_RUN  = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic               running;
    logic [31:0]        now_ms;
  } lmi_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        travel_ms;
    logic               arrived;
  } lmi_out_t;

  // shared unit operation
  typedef enum logic [1:0] {
    OP_SQRT,
    OP_DIV
  } lmi_op_t;

  typedef struct packed {
    logic    start;
    lmi_op_t op;
  } lmi_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_SQRT_W,
    ST_TDIV,
    ST_TDIV_W,
    ST_QMUL,
    ST_QDIV,
    ST_QDIV_W,
    ST_OUT
  } lmi_state_t;

endpackage
`default_nettype wire

>>> src/lmi_unit.sv
`default_nettype none
// Shared iterative unit: restoring square root of a 128-bit radicand
// (one result bit a cycle) or restoring division of a 96-bit dividend
// by a 32-bit divisor (one quotient bit a cycle).
module lmi_unit
  import lmi_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire lmi_ctl_t     ctl,
  input  wire logic [127:0] opa,
  input  wire logic [31:0]  opb,
  output logic              busy,
  output logic [95:0]       res
);

  logic [127:0] sh_r, sh_nxt;
  logic [97:0]  rem_r, rem_nxt;
  logic [95:0]  q_r, q_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  lmi_op_t      op_r, op_nxt;
  logic [97:0]  trial, rem_sh;

  always_comb begin
    sh_nxt = sh_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    op_nxt = op_r;
    rem_sh = '0;
    trial = '0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt = ctl.op;
      rem_nxt = '0;
      q_nxt = '0;
      if (ctl.op == OP_SQRT) begin
        sh_nxt = opa;
        cnt_nxt = 7'd63;
      end else begin
        sh_nxt = {opa[95:0], 32'd0};
        cnt_nxt = 7'd95;
      end
    end else if (busy_r) begin
      if (op_r == OP_SQRT) begin
        rem_sh = {rem_r[95:0], sh_r[127:126]};
        trial = {q_r[95:0], 2'b01};
        sh_nxt = {sh_r[125:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt = rem_sh - trial;
          q_nxt = {q_r[94:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          q_nxt = {q_r[94:0], 1'b0};
        end
      end else begin
        rem_sh = {rem_r[96:0], sh_r[127]};
        trial = {66'd0, opb};
        sh_nxt = {sh_r[126:0], 1'b0};
        if (rem_sh >= trial) begin
          rem_nxt = rem_sh - trial;
          q_nxt = {q_r[94:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          q_nxt = {q_r[94:0], 1'b0};
        end
      end
      if (cnt_r == 7'd0) begin
        busy_nxt = 1'b0;
      end
      cnt_nxt = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      op_r <= OP_SQRT;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
      op_r <= op_nxt;
    end
    sh_r <= sh_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
  end

  assign busy = busy_r;
  assign res = q_r;

endmodule
`default_nettype wire

>>> src/linear_move_interpolator.sv
// channel | direction | handshake       | payload
// in_     | input     | in_valid/stall  | lmi_in_t
// out_    | output    | out_valid/stall | lmi_out_t
// cfg_    | input     | valid/ready     | index, 32-bit data
// Set: two squaring passes (over two axes, then three), two roots and two divisions, then
// the result. Retarget: one squaring pass over two axes, one root and one division.
// Query: three divisions with set-up, or none once the move is over, all on the shared
// bit-serial unit. The result is held while out_stall is high.
// Reset is synchronous; start and end positions, total and start times and speeds return to their reset values.
// in_stall stays high from acceptance until the result is taken at out_.
`default_nettype none
module linear_move_interpolator
  import lmi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire lmi_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output lmi_out_t      out_data,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic     cfg_index,
  input  wire logic [31:0] cfg_data
);

  lmi_state_t st_r, st_nxt;
  logic [31:0] walk_r, run_r, speed_r;
  logic [31:0] sp_r [3];
  logic [31:0] ep_r [3];
  logic [31:0] total_r, tstart_r, elapsed_r, travel_r;
  logic        set_r, phase3_r, busy_seen_r;
  logic [1:0]  ax_r;
  logic [65:0] sum_r;
  logic [95:0] dividend_r;
  logic [31:0] divisor_r;
  logic [31:0] res_x_r, res_y_r, res_z_r;
  logic        arrived_r;
  lmi_ctl_t    ctl;
  logic        ubusy;
  logic [95:0] ures;
  logic [127:0] opa;
  logic [32:0] dax;
  logic [32:0] mag;
  logic [63:0] prod;
  logic [63:0] sq;
  logic [31:0] tq;
  logic [31:0] elapsed_now;
  logic        in_acc;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE);
  assign cfg_ready = (st_r == ST_IDLE);

  lmi_unit u_unit (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .opa(opa), .opb(divisor_r),
    .busy(ubusy), .res(ures)
  );

  assign opa = (st_r == ST_SQRT) ? {30'd0, sum_r, 32'd0} : {32'd0, dividend_r};
  assign dax = {ep_r[ax_r][31], ep_r[ax_r]} - {sp_r[ax_r][31], sp_r[ax_r]};
  assign mag = dax[32] ? (~dax + 33'd1) : dax;
  assign prod = mag[31:0] * elapsed_r;
  assign sq = mag[31:0] * mag[31:0];
  assign tq = ures[31:0];
  assign elapsed_now = in_data.now_ms - tstart_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (in_acc) st_nxt = (in_data.cmd == CMD_SET || in_data.cmd == CMD_RETGT) ?
                   ST_SQ : ST_QMUL;
      ST_SQ:     if (ax_r == (phase3_r ? 2'd2 : 2'd1)) st_nxt = ST_SQRT;
      ST_SQRT:   st_nxt = ST_SQRT_W;
      ST_SQRT_W: if (busy_seen_r && !ubusy) st_nxt = ST_TDIV;
      ST_TDIV:   st_nxt = ST_TDIV_W;
      ST_TDIV_W: if (busy_seen_r && !ubusy) st_nxt = (set_r && !phase3_r) ? ST_SQ : ST_OUT;
      ST_QMUL:   st_nxt = arrived_r ? ST_OUT : ST_QDIV;
      ST_QDIV:   st_nxt = ST_QDIV_W;
      ST_QDIV_W: if (busy_seen_r && !ubusy) st_nxt = (ax_r == 2'd2) ? ST_OUT : ST_QMUL;
      ST_OUT:    if (!out_stall) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.start = (st_r == ST_SQRT) || (st_r == ST_TDIV) || (st_r == ST_QDIV);
    ctl.op = (st_r == ST_SQRT) ? OP_SQRT : OP_DIV;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      walk_r <= SpeedReset;
      run_r <= SpeedReset;
      for (int i = 0; i < 3; i++) begin
        sp_r[i] <= '0;
        ep_r[i] <= '0;
      end
      total_r <= '0;
      tstart_r <= '0;
      busy_seen_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WALK) walk_r <= cfg_data;
        else run_r <= cfg_data;
      end
      busy_seen_r <= ctl.start ? 1'b0 : (busy_seen_r | ubusy);
      if (st_r == ST_IDLE && in_acc && (in_data.cmd == CMD_SET || in_data.cmd == CMD_RETGT))
      begin
        if (in_data.cmd == CMD_SET) begin
          sp_r[0] <= in_data.cur_x;
          sp_r[1] <= in_data.cur_y;
          sp_r[2] <= in_data.cur_z;
        end
        ep_r[0] <= in_data.target_x;
        ep_r[1] <= in_data.target_y;
        ep_r[2] <= in_data.target_z;
        tstart_r <= in_data.now_ms;
      end
      if (st_r == ST_TDIV_W && busy_seen_r && !ubusy && !phase3_r) begin
        total_r <= (ures[95:32] != '0) ? 32'hFFFF_FFFF : ures[31:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          set_r <= (in_data.cmd == CMD_SET);
          phase3_r <= 1'b0;
          ax_r <= 2'd0;
          sum_r <= '0;
          speed_r <= (in_data.running ? run_r : walk_r) == '0 ? 32'd1 :
                     (in_data.running ? run_r : walk_r);
          elapsed_r <= elapsed_now;
          // only a query can report arrival
          arrived_r <= !(in_data.cmd == CMD_SET || in_data.cmd == CMD_RETGT) &&
                       ((total_r == '0) || (elapsed_now >= total_r));
          travel_r <= '0;
        end
      end
      ST_SQ: begin
        sum_r <= sum_r + {2'd0, sq};
        if (st_nxt == ST_SQ) ax_r <= ax_r + 2'd1;
      end
      ST_SQRT_W: if (st_nxt == ST_TDIV) begin
        dividend_r <= {31'd0, ures[64:0]} + {64'd0, 1'b0, speed_r[31:1]};
        divisor_r <= speed_r;
      end
      ST_TDIV_W: if (busy_seen_r && !ubusy) begin
        if (phase3_r || !set_r)
          travel_r <= (ures[95:32] != '0) ? 32'hFFFF_FFFF : ures[31:0];
        if (set_r && !phase3_r) begin
          phase3_r <= 1'b1;
          ax_r <= 2'd0;
          sum_r <= '0;
        end
        res_x_r <= sp_r[0];
        res_y_r <= sp_r[1];
        res_z_r <= sp_r[2];
      end
      ST_QMUL: begin
        if (arrived_r) begin
          res_x_r <= ep_r[0];
          res_y_r <= ep_r[1];
          res_z_r <= ep_r[2];
        end
        dividend_r <= {32'd0, prod};
        divisor_r <= total_r;
      end
      ST_QDIV_W: if (busy_seen_r && !ubusy) begin
        case (ax_r)
          2'd0: res_x_r <= dax[32] ? sp_r[0] - tq : sp_r[0] + tq;
          2'd1: res_y_r <= dax[32] ? sp_r[1] - tq : sp_r[1] + tq;
          default: res_z_r <= dax[32] ? sp_r[2] - tq : sp_r[2] + tq;
        endcase
        ax_r <= ax_r + 2'd1;
      end
      default: ;
    endcase
  end

  assign out_valid = (st_r == ST_OUT);
  assign out_data.pos_x = res_x_r;
  assign out_data.pos_y = res_y_r;
  assign out_data.pos_z = res_z_r;
  assign out_data.travel_ms = travel_r;
  assign out_data.arrived = arrived_r;

`ifndef SYNTH
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ubusy |-> in_stall) else $error("item accepted while unit busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !out_valid) else $error("cfg open with result pending");
`endif

endmodule
`default_nettype wire
